// File: hdl/hds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int ADDR_W   = 1 + ROW_W + COL_W;
   localparam int DEPTH    = 2 ** ADDR_W;
   localparam int VAL_W    = 24;
   localparam int ACC_W    = 28;
   localparam int RATIO_W  = 15;
   localparam int PROD_W   = ACC_W + RATIO_W + 1;
   localparam int SUM_W    = ACC_W + 1;
   localparam int DIM_W    = 7;
   localparam int FRAC_SH  = 16;

   localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(16384);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(6554);
   localparam logic [DIM_W-1:0]   DIM_MIN     = DIM_W'(3);
   localparam logic [DIM_W-1:0]   ROWS_MAX    = DIM_W'(MAX_ROWS);
   localparam logic [DIM_W-1:0]   COLS_MAX    = DIM_W'(MAX_COLS);

   // operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_KEEP    = 2'd2;
   localparam logic [1:0] OP_ADVANCE = 2'd3;

   // edge kinds
   localparam logic [2:0] KIND_INTERIOR  = 3'd0;
   localparam logic [2:0] KIND_LAST_ROW  = 3'd1;
   localparam logic [2:0] KIND_FIRST_ROW = 3'd2;
   localparam logic [2:0] KIND_LAST_COL  = 3'd3;
   localparam logic [2:0] KIND_FIRST_COL = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_RATIO = 2'd0;
   localparam logic [1:0] CSR_ROWS  = 2'd1;
   localparam logic [1:0] CSR_COLS  = 2'd2;

   // stencil terms in read order
   localparam logic [2:0] TERM_C  = 3'd0;
   localparam logic [2:0] TERM_UP = 3'd1;
   localparam logic [2:0] TERM_DN = 3'd2;
   localparam logic [2:0] TERM_LF = 3'd3;
   localparam logic [2:0] TERM_RT = 3'd4;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_INIT,
      ALU_ADD1,
      ALU_ADD2,
      ALU_MUL
   } alu_cmd_type;

   typedef struct packed {
      alu_cmd_type        cmd;
      logic [RATIO_W-1:0] ratio;
   } alu_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_DRAIN,
      ST_MUL,
      ST_FIN,
      ST_KEEP
   } state_type;

endpackage

`default_nettype wire

// File: hdl/hds_grid_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hds_grid_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [hds_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [hds_pkg::VAL_W-1:0]   wr_data,
   input  wire logic                        rd_en,
   input  wire logic [hds_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [hds_pkg::VAL_W-1:0]   rd_data
);

   logic [hds_pkg::VAL_W-1:0] grid_mem [hds_pkg::DEPTH];
   logic [hds_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      // hold the last word when no read is issued
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/hds_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module hds_alu (
   input  wire logic                               clock,
   input  wire hds_pkg::alu_ctl_type               ctl,
   input  wire logic signed [hds_pkg::VAL_W-1:0]   operand,
   output logic signed      [hds_pkg::VAL_W-1:0]   result
);

   logic signed [hds_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [hds_pkg::VAL_W-1:0]  center_ff, center_in;
   logic signed [hds_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [hds_pkg::ACC_W-1:0]  term;
   logic signed [hds_pkg::PROD_W-1:0] ratio_ext;
   logic signed [hds_pkg::PROD_W-1:0] rnd_full;
   logic signed [hds_pkg::ACC_W-1:0]  rnd;
   logic signed [hds_pkg::SUM_W-1:0]  sum;

   localparam logic signed [hds_pkg::PROD_W-1:0] HALF_LSB =
      hds_pkg::PROD_W'(2 ** (hds_pkg::FRAC_SH - 1));
   localparam logic signed [hds_pkg::SUM_W-1:0] SAT_HI =
      hds_pkg::SUM_W'(2 ** (hds_pkg::VAL_W - 1) - 1);
   localparam logic signed [hds_pkg::SUM_W-1:0] SAT_LO =
      -hds_pkg::SUM_W'(2 ** (hds_pkg::VAL_W - 1));

   always_comb begin
      acc_in    = acc_ff;
      center_in = center_ff;
      prod_in   = prod_ff;
      term      = hds_pkg::ACC_W'(operand);
      ratio_ext = $signed(hds_pkg::PROD_W'(ctl.ratio));
      case (ctl.cmd)
         hds_pkg::ALU_INIT: begin
            center_in = operand;
            acc_in    = -(term <<< 2);
         end
         hds_pkg::ALU_ADD1: acc_in = acc_ff + term;
         hds_pkg::ALU_ADD2: acc_in = acc_ff + (term <<< 1);
         hds_pkg::ALU_MUL:  prod_in = hds_pkg::PROD_W'(acc_ff) * ratio_ext;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      center_ff <= center_in;
      prod_ff   <= prod_in;
   end

   // round half up, drop the fraction, add back the center, saturate
   always_comb begin
      rnd_full = prod_ff + HALF_LSB;
      rnd      = $signed(rnd_full[hds_pkg::PROD_W-1:hds_pkg::FRAC_SH]);
      sum      = hds_pkg::SUM_W'(center_ff) + hds_pkg::SUM_W'(rnd);
      if (sum > SAT_HI) begin
         result = hds_pkg::VAL_W'(SAT_HI);
      end else if (sum < SAT_LO) begin
         result = hds_pkg::VAL_W'(SAT_LO);
      end else begin
         result = sum[hds_pkg::VAL_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: hdl/heat_diffusion_stencil_insulated_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Five-point heat step engine over a double-buffered 64x64 grid, Q12.12 values.
// req_ channel: one word per operation (load, compute, keep, advance); req_ready
// is high only while the sequencer is idle. rsp_ channel: exactly one word per
// request, in order, with the value and a status bit (1 = cell off the grid, or
// a non-edge kind given for an edge cell; value then zero).
// csr_ channel: always ready; index 0 ratio, 1 rows, 2 cols; other indexes are
// dropped. Write it only while no request is in flight.
// Load, advance and rejected words respond from the execute state, keep via a
// keep state, compute via read, drain, multiply and finish states. A new request
// is taken the cycle after the response is loaded. The compute path is set by
// the single read port of the grid RAM: five words (center and four neighbors)
// are read one per cycle and folded in by one shared accumulate/multiply unit,
// then one multiply, one round/saturate and a write.
// Reset (synchronous) sets bank a current and loads the register defaults;
// grid contents are left as they are and must be loaded before use.
// The response register lets a new request enter while the last response is
// still waiting; a finished result then waits in the sequencer until rsp_ready.

module heat_diffusion_stencil_insulated_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_operation,
   input  wire logic [hds_pkg::ROW_W-1:0]           req_row,
   input  wire logic [hds_pkg::COL_W-1:0]           req_col,
   input  wire logic [2:0]                          req_edge_kind,
   input  wire logic signed [hds_pkg::VAL_W-1:0]    req_load_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [hds_pkg::VAL_W-1:0]         rsp_result_value,
   output logic                                     rsp_status,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [hds_pkg::RATIO_W-1:0]         csr_data
);

   hds_pkg::state_type state_ff, state_in;

   logic [hds_pkg::RATIO_W-1:0] ratio_ff;
   logic [hds_pkg::DIM_W-1:0]   rows_ff, cols_ff;
   logic                        bank_ff, bank_in;

   logic [1:0]                   op_ff;
   logic [hds_pkg::ROW_W-1:0]    row_ff;
   logic [hds_pkg::COL_W-1:0]    col_ff;
   logic [2:0]                   kind_ff;
   logic signed [hds_pkg::VAL_W-1:0] load_ff;

   logic [2:0] term_ff, term_in;
   logic [2:0] pterm_ff, pterm_in;
   logic       pend_ff, pend_in;
   logic [2:0] iss_term;

   logic                            rsp_valid_ff;
   logic signed [hds_pkg::VAL_W-1:0] rsp_value_ff;
   logic                            rsp_status_ff;
   logic                            rsp_load;
   logic signed [hds_pkg::VAL_W-1:0] rsp_value_in;
   logic                            rsp_status_in;
   logic                            out_free;

   logic [hds_pkg::DIM_W-1:0] nr, nc, nr_m1, nc_m1, nr_m2, nc_m2, rp1, cp1;
   logic [hds_pkg::ROW_W-1:0] up_row, dn_row;
   logic [hds_pkg::COL_W-1:0] lf_col, rt_col;
   logic                      outside, on_edge, kind_ok;
   logic [hds_pkg::RATIO_W-1:0] ratio_eff;

   logic                       rd_en, wr_en;
   logic [hds_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic [hds_pkg::VAL_W-1:0]  wr_data, rd_data;
   hds_pkg::alu_ctl_type       alu_ctl;
   logic signed [hds_pkg::VAL_W-1:0] alu_result;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == hds_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= hds_pkg::RATIO_RESET;
         rows_ff  <= hds_pkg::ROWS_MAX;
         cols_ff  <= hds_pkg::COLS_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            hds_pkg::CSR_RATIO: ratio_ff <= csr_data;
            hds_pkg::CSR_ROWS:  rows_ff  <= csr_data[hds_pkg::DIM_W-1:0];
            hds_pkg::CSR_COLS:  cols_ff  <= csr_data[hds_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // geometry and mirrored neighbor indexes
   always_comb begin
      if (rows_ff < hds_pkg::DIM_MIN) nr = hds_pkg::DIM_MIN;
      else if (rows_ff > hds_pkg::ROWS_MAX) nr = hds_pkg::ROWS_MAX;
      else nr = rows_ff;
      if (cols_ff < hds_pkg::DIM_MIN) nc = hds_pkg::DIM_MIN;
      else if (cols_ff > hds_pkg::COLS_MAX) nc = hds_pkg::COLS_MAX;
      else nc = cols_ff;
      ratio_eff = (ratio_ff > hds_pkg::RATIO_MAX) ? hds_pkg::RATIO_MAX : ratio_ff;

      nr_m1 = nr - hds_pkg::DIM_W'(1);
      nc_m1 = nc - hds_pkg::DIM_W'(1);
      nr_m2 = nr - hds_pkg::DIM_W'(2);
      nc_m2 = nc - hds_pkg::DIM_W'(2);
      rp1   = hds_pkg::DIM_W'(row_ff) + hds_pkg::DIM_W'(1);
      cp1   = hds_pkg::DIM_W'(col_ff) + hds_pkg::DIM_W'(1);

      up_row = (row_ff == '0) ? hds_pkg::ROW_W'(1) : row_ff - hds_pkg::ROW_W'(1);
      dn_row = (rp1 >= nr) ? nr_m2[hds_pkg::ROW_W-1:0] : rp1[hds_pkg::ROW_W-1:0];
      lf_col = (col_ff == '0) ? hds_pkg::COL_W'(1) : col_ff - hds_pkg::COL_W'(1);
      rt_col = (cp1 >= nc) ? nc_m2[hds_pkg::COL_W-1:0] : cp1[hds_pkg::COL_W-1:0];

      outside = (hds_pkg::DIM_W'(row_ff) >= nr) || (hds_pkg::DIM_W'(col_ff) >= nc);
      on_edge = (row_ff == '0) || (hds_pkg::DIM_W'(row_ff) == nr_m1) ||
                (col_ff == '0) || (hds_pkg::DIM_W'(col_ff) == nc_m1);
      kind_ok = kind_ff inside {hds_pkg::KIND_LAST_ROW, hds_pkg::KIND_FIRST_ROW,
                                hds_pkg::KIND_LAST_COL, hds_pkg::KIND_FIRST_COL};
   end

   // read address for the term being issued, always from the current bank
   always_comb begin
      case (iss_term)
         hds_pkg::TERM_UP: rd_addr = {bank_ff, up_row, col_ff};
         hds_pkg::TERM_DN: rd_addr = {bank_ff, dn_row, col_ff};
         hds_pkg::TERM_LF: rd_addr = {bank_ff, row_ff, lf_col};
         hds_pkg::TERM_RT: rd_addr = {bank_ff, row_ff, rt_col};
         default:          rd_addr = {bank_ff, row_ff, col_ff};
      endcase
   end

   // weight of the word now on the read port; the mirrored side counts twice
   always_comb begin
      alu_ctl.ratio = ratio_eff;
      alu_ctl.cmd   = hds_pkg::ALU_NOP;
      if (state_ff == hds_pkg::ST_MUL) begin
         alu_ctl.cmd = hds_pkg::ALU_MUL;
      end else if (pend_ff) begin
         case (pterm_ff)
            hds_pkg::TERM_C: alu_ctl.cmd = hds_pkg::ALU_INIT;
            hds_pkg::TERM_UP: begin
               if (kind_ff == hds_pkg::KIND_LAST_ROW) alu_ctl.cmd = hds_pkg::ALU_ADD2;
               else if (kind_ff == hds_pkg::KIND_FIRST_ROW) alu_ctl.cmd = hds_pkg::ALU_NOP;
               else alu_ctl.cmd = hds_pkg::ALU_ADD1;
            end
            hds_pkg::TERM_DN: begin
               if (kind_ff == hds_pkg::KIND_FIRST_ROW) alu_ctl.cmd = hds_pkg::ALU_ADD2;
               else if (kind_ff == hds_pkg::KIND_LAST_ROW) alu_ctl.cmd = hds_pkg::ALU_NOP;
               else alu_ctl.cmd = hds_pkg::ALU_ADD1;
            end
            hds_pkg::TERM_LF: begin
               if (kind_ff == hds_pkg::KIND_LAST_COL) alu_ctl.cmd = hds_pkg::ALU_ADD2;
               else if (kind_ff == hds_pkg::KIND_FIRST_COL) alu_ctl.cmd = hds_pkg::ALU_NOP;
               else alu_ctl.cmd = hds_pkg::ALU_ADD1;
            end
            hds_pkg::TERM_RT: begin
               if (kind_ff == hds_pkg::KIND_FIRST_COL) alu_ctl.cmd = hds_pkg::ALU_ADD2;
               else if (kind_ff == hds_pkg::KIND_LAST_COL) alu_ctl.cmd = hds_pkg::ALU_NOP;
               else alu_ctl.cmd = hds_pkg::ALU_ADD1;
            end
            default: alu_ctl.cmd = hds_pkg::ALU_NOP;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      term_in       = term_ff;
      pterm_in      = pterm_ff;
      pend_in       = 1'b0;
      iss_term      = hds_pkg::TERM_C;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = {~bank_ff, row_ff, col_ff};
      wr_data       = alu_result;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = 1'b0;
      case (state_ff)
         hds_pkg::ST_IDLE: begin
            if (req_valid) state_in = hds_pkg::ST_EXEC;
         end
         hds_pkg::ST_EXEC: begin
            if (op_ff == hds_pkg::OP_ADVANCE) begin
               if (out_free) begin
                  bank_in  = ~bank_ff;
                  rsp_load = 1'b1;
                  state_in = hds_pkg::ST_IDLE;
               end
            end else if (outside ||
                         (op_ff == hds_pkg::OP_COMPUTE && on_edge && !kind_ok)) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = 1'b1;
                  state_in      = hds_pkg::ST_IDLE;
               end
            end else if (op_ff == hds_pkg::OP_LOAD) begin
               if (out_free) begin
                  wr_en        = 1'b1;
                  wr_addr      = {bank_ff, row_ff, col_ff};
                  wr_data      = load_ff;
                  rsp_load     = 1'b1;
                  rsp_value_in = load_ff;
                  state_in     = hds_pkg::ST_IDLE;
               end
            end else if (op_ff == hds_pkg::OP_KEEP) begin
               rd_en    = 1'b1;
               state_in = hds_pkg::ST_KEEP;
            end else begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               pterm_in = hds_pkg::TERM_C;
               term_in  = hds_pkg::TERM_UP;
               state_in = hds_pkg::ST_READ;
            end
         end
         hds_pkg::ST_READ: begin
            iss_term = term_ff;
            rd_en    = 1'b1;
            pend_in  = 1'b1;
            pterm_in = term_ff;
            term_in  = term_ff + 3'd1;
            if (term_ff == hds_pkg::TERM_RT) state_in = hds_pkg::ST_DRAIN;
         end
         hds_pkg::ST_DRAIN: state_in = hds_pkg::ST_MUL;
         hds_pkg::ST_MUL:   state_in = hds_pkg::ST_FIN;
         hds_pkg::ST_FIN: begin
            if (out_free) begin
               wr_en        = 1'b1;
               rsp_load     = 1'b1;
               rsp_value_in = alu_result;
               state_in     = hds_pkg::ST_IDLE;
            end
         end
         hds_pkg::ST_KEEP: begin
            if (out_free) begin
               wr_en        = 1'b1;
               wr_data      = rd_data;
               rsp_load     = 1'b1;
               rsp_value_in = $signed(rd_data);
               state_in     = hds_pkg::ST_IDLE;
            end
         end
         default: state_in = hds_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hds_pkg::ST_IDLE;
         bank_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         pend_ff  <= pend_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      term_ff  <= term_in;
      pterm_ff <= pterm_in;
      if (req_valid && req_ready) begin
         op_ff   <= req_operation;
         row_ff  <= req_row;
         col_ff  <= req_col;
         kind_ff <= req_edge_kind;
         load_ff <= req_load_value;
      end
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   hds_grid_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hds_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .operand ($signed(rd_data)),
      .result  (alu_result)
   );

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == hds_pkg::ST_EXEC))
      else $error("accepted word did not start execution");

   a_write_responds : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff)
      else $error("grid write without a response");

   a_status_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_value_ff == '0))
      else $error("rejected word carries a nonzero value");

   a_bank_swap : assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |->
         $past(state_ff == hds_pkg::ST_EXEC && op_ff == hds_pkg::OP_ADVANCE))
      else $error("bank swapped outside an advance");

   a_read_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == hds_pkg::ST_IDLE) |-> !rd_en && !wr_en)
      else $error("grid access while idle");

endmodule

`default_nettype wire

// File: tb/heat_diffusion_stencil_insulated_core_test.sv
`timescale 1ns / 1ps

module heat_diffusion_stencil_insulated_core_test;
   import hds_pkg::*;

   localparam int CELL_COUNT    = MAX_ROWS * MAX_COLS;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_CYCLES  = 300;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   localparam logic signed [VAL_W-1:0] TEMP_MAX = 24'sh7FFFFF;
   localparam logic signed [VAL_W-1:0] TEMP_MIN = 24'sh800000;

   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    status;
   } temp_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_operation = OP_LOAD;
   logic [ROW_W-1:0]            req_row = '0;
   logic [COL_W-1:0]            req_col = '0;
   logic [2:0]                  req_edge_kind = KIND_INTERIOR;
   logic signed [VAL_W-1:0]     req_load_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [VAL_W-1:0]     rsp_result_value;
   logic                        rsp_status;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [1:0]                  csr_index = CSR_RATIO;
   logic [RATIO_W-1:0]          csr_data = '0;

   // predicted grid state and registers
   logic signed [VAL_W-1:0]     grid_temp [0:1][0:CELL_COUNT-1];
   bit                          grid_loaded [0:1][0:CELL_COUNT-1];
   bit                          live_bank = 1'b0;
   logic [RATIO_W-1:0]          ratio_q16 = RATIO_RESET;
   logic [DIM_W-1:0]            rows_setting = ROWS_MAX;
   logic [DIM_W-1:0]            cols_setting = COLS_MAX;
   temp_word_type               expected_temps [$];
   temp_word_type               oldest_temp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int stall_left    = 0;
   int cycle_count   = 0;
   int mismatches    = 0;
   int words_sent    = 0;
   int rejects       = 0;
   int settings_used = 0;
   int op_tally [4]  = '{0, 0, 0, 0};

   heat_diffusion_stencil_insulated_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_edge_kind    (req_edge_kind),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random idling, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_temps.size() == 0) begin
            $error("result word with nothing expected: result_value %0d status %0d",
                   rsp_result_value, rsp_status);
            mismatches++;
         end else begin
            oldest_temp = expected_temps.pop_front();
            if (rsp_result_value !== oldest_temp.value) begin
               $error("result_value: expected %0d, actual %0d",
                      oldest_temp.value, rsp_result_value);
               mismatches++;
            end
            if (rsp_status !== oldest_temp.status) begin
               $error("status: expected %0d, actual %0d", oldest_temp.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
      if (v < DIM_MIN) return int'(DIM_MIN);
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic int active_rows();
      return clamp_dim(rows_setting, MAX_ROWS);
   endfunction

   function automatic int active_cols();
      return clamp_dim(cols_setting, MAX_COLS);
   endfunction

   // fold an index that fell off the grid back onto its mirror
   function automatic int fold_index(int k, int n);
      if (k < 0) return 1;
      if (k >= n) return n - 2;
      return k;
   endfunction

   function automatic int cell_addr(int row, int col);
      return row * MAX_COLS + col;
   endfunction

   function automatic bit stencil_loaded(int row, int col);
      int nr, nc;
      nr = active_rows();
      nc = active_cols();
      if (row >= nr || col >= nc) return 1'b1;
      return grid_loaded[live_bank][cell_addr(row, col)]
         && grid_loaded[live_bank][cell_addr(fold_index(row - 1, nr), col)]
         && grid_loaded[live_bank][cell_addr(fold_index(row + 1, nr), col)]
         && grid_loaded[live_bank][cell_addr(row, fold_index(col - 1, nc))]
         && grid_loaded[live_bank][cell_addr(row, fold_index(col + 1, nc))];
   endfunction

   function automatic temp_word_type step_temperature(logic [1:0] op, int row, int col,
                                                      logic [2:0] kind,
                                                      logic signed [VAL_W-1:0] load);
      temp_word_type outw;
      int nr, nc, a;
      longint ctr, up, dn, lf, rt, sum, r, v;
      bit edge_cell, ok;
      outw.value = '0;
      outw.status = 1'b0;
      nr = active_rows();
      nc = active_cols();
      if (op == OP_ADVANCE) begin
         live_bank = !live_bank;
      end else if (row >= nr || col >= nc) begin
         outw.status = 1'b1;
      end else begin
         a = cell_addr(row, col);
         case (op)
            OP_LOAD: begin
               grid_temp[live_bank][a] = load;
               grid_loaded[live_bank][a] = 1'b1;
               outw.value = load;
            end
            OP_KEEP: begin
               grid_temp[!live_bank][a] = grid_temp[live_bank][a];
               grid_loaded[!live_bank][a] = 1'b1;
               outw.value = grid_temp[live_bank][a];
            end
            default: begin
               ctr = grid_temp[live_bank][a];
               up = grid_temp[live_bank][cell_addr(fold_index(row - 1, nr), col)];
               dn = grid_temp[live_bank][cell_addr(fold_index(row + 1, nr), col)];
               lf = grid_temp[live_bank][cell_addr(row, fold_index(col - 1, nc))];
               rt = grid_temp[live_bank][cell_addr(row, fold_index(col + 1, nc))];
               edge_cell = row == 0 || row == nr - 1 || col == 0 || col == nc - 1;
               ok = 1'b1;
               case (kind)
                  KIND_LAST_ROW:  sum = 2 * up + lf + rt;
                  KIND_FIRST_ROW: sum = 2 * dn + lf + rt;
                  KIND_LAST_COL:  sum = up + dn + 2 * lf;
                  KIND_FIRST_COL: sum = up + dn + 2 * rt;
                  default: begin
                     sum = up + dn + lf + rt;
                     ok = !edge_cell;
                  end
               endcase
               if (!ok) begin
                  outw.status = 1'b1;
               end else begin
                  r = (ratio_q16 > RATIO_MAX) ? RATIO_MAX : ratio_q16;
                  // round half up, then saturate to Q12.12
                  v = ctr + (((sum - 4 * ctr) * r + 32768) >>> FRAC_SH);
                  if (v > TEMP_MAX) v = TEMP_MAX;
                  if (v < TEMP_MIN) v = TEMP_MIN;
                  grid_temp[!live_bank][a] = v[VAL_W-1:0];
                  grid_loaded[!live_bank][a] = 1'b1;
                  outw.value = v[VAL_W-1:0];
               end
            end
         endcase
      end
      return outw;
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_temp();
      case ($urandom_range(9))
         0: return TEMP_MAX;
         1: return TEMP_MIN;
         2, 3: return VAL_W'($urandom);
         default: return VAL_W'(int'($urandom_range(81920)) - 40960);
      endcase
   endfunction

   function automatic logic [RATIO_W-1:0] pick_ratio();
      case ($urandom_range(7))
         0: return '0;
         1: return RATIO_MAX;
         2: return '1;
         3: return RATIO_W'($urandom);
         default: return RATIO_W'($urandom_range(16384));
      endcase
   endfunction

   function automatic logic [RATIO_W-1:0] pick_dim();
      case ($urandom_range(9))
         0: return '0;
         1: return RATIO_W'(MAX_ROWS);
         2: return RATIO_W'($urandom);
         3: return RATIO_W'(127);
         default: return RATIO_W'($urandom_range(3, 8));
      endcase
   endfunction

   // edge kind matching the cell (corners pick one of two), else interior or unused
   function automatic logic [2:0] fitting_kind(int row, int col);
      int nr, nc, hits;
      logic [2:0] pick;
      nr = active_rows();
      nc = active_cols();
      hits = 0;
      pick = KIND_INTERIOR;
      if (row == 0) begin
         hits++;
         if ($urandom_range(hits - 1) == 0) pick = KIND_FIRST_ROW;
      end
      if (row == nr - 1) begin
         hits++;
         if ($urandom_range(hits - 1) == 0) pick = KIND_LAST_ROW;
      end
      if (col == 0) begin
         hits++;
         if ($urandom_range(hits - 1) == 0) pick = KIND_FIRST_COL;
      end
      if (col == nc - 1) begin
         hits++;
         if ($urandom_range(hits - 1) == 0) pick = KIND_LAST_COL;
      end
      if (hits == 0 && $urandom_range(3) == 0)
         pick = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      return pick;
   endfunction

   task automatic send_word(logic [1:0] op, int row, int col, logic [2:0] kind,
                            logic signed [VAL_W-1:0] load);
      temp_word_type predicted;
      // never let the block read a cell that was not written: load it instead
      if ((op == OP_COMPUTE && !stencil_loaded(row, col))
          || (op == OP_KEEP && row < active_rows() && col < active_cols()
              && !grid_loaded[live_bank][cell_addr(row, col)])) begin
         op = OP_LOAD;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_row        <= row[ROW_W-1:0];
      req_col        <= col[COL_W-1:0];
      req_edge_kind  <= kind;
      req_load_value <= load;
      predicted = step_temperature(op, row, col, kind, load);
      expected_temps.insert(expected_temps.size(), predicted);
      if (predicted.status) rejects++;
      op_tally[op]++;
      words_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_noise();
      int nr, nc, row, col;
      logic [1:0] op;
      nr = active_rows();
      nc = active_cols();
      if ($urandom_range(1)) begin
         row = $urandom_range(nr - 1);
         col = $urandom_range(nc - 1);
      end else begin
         row = $urandom_range(MAX_ROWS - 1);
         col = $urandom_range(MAX_COLS - 1);
      end
      case ($urandom_range(7))
         0, 1, 2: op = OP_LOAD;
         3, 4:    op = OP_COMPUTE;
         5, 6:    op = OP_KEEP;
         default: op = OP_ADVANCE;
      endcase
      send_word(op, row, col, 3'($urandom), VAL_W'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_temps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [RATIO_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RATIO: ratio_q16 = data;
         CSR_ROWS:  rows_setting = data[DIM_W-1:0];
         CSR_COLS:  cols_setting = data[DIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(logic [RATIO_W-1:0] ratio, logic [RATIO_W-1:0] rows,
                            logic [RATIO_W-1:0] cols);
      drain_results();
      csr_write(CSR_RATIO, ratio);
      csr_write(CSR_ROWS, rows);
      csr_write(CSR_COLS, cols);
      // the spare index must be dropped
      csr_write(CSR_UNUSED, RATIO_W'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // fill a window of the grid, then run heat steps over it with some noise mixed in
   task automatic run_sweeps(int steps, int noise_pct);
      int nr, nc, h, w, r0, c0;
      nr = active_rows();
      nc = active_cols();
      if (nr * nc <= 64) begin
         h = nr;
         w = nc;
         r0 = 0;
         c0 = 0;
      end else begin
         h = $urandom_range(3, 8);
         w = $urandom_range(3, 8);
         if (h > nr) h = nr;
         if (w > nc) w = nc;
         case ($urandom_range(2))
            0: r0 = 0;
            1: r0 = nr - h;
            default: r0 = $urandom_range(nr - h);
         endcase
         case ($urandom_range(2))
            0: c0 = 0;
            1: c0 = nc - w;
            default: c0 = $urandom_range(nc - w);
         endcase
      end
      for (int r = r0; r < r0 + h; r++)
         for (int c = c0; c < c0 + w; c++)
            send_word(OP_LOAD, r, c, 3'($urandom), pick_temp());
      repeat (steps) begin
         for (int r = r0; r < r0 + h; r++) begin
            for (int c = c0; c < c0 + w; c++) begin
               if ($urandom_range(99) < noise_pct) send_noise();
               // rim cells missing loaded neighbors and a random tenth are kept
               if ($urandom_range(9) == 0 || !stencil_loaded(r, c))
                  send_word(OP_KEEP, r, c, 3'($urandom), VAL_W'($urandom));
               else
                  send_word(OP_COMPUTE, r, c, fitting_kind(r, c), VAL_W'($urandom));
            end
         end
         send_word(OP_ADVANCE, $urandom_range(63), $urandom_range(63), 3'($urandom),
                   VAL_W'($urandom));
      end
   endtask

   task automatic test_directed_cells();
      send_word(OP_LOAD, 0, 0, KIND_INTERIOR, TEMP_MAX);
      send_word(OP_LOAD, 1, 0, KIND_INTERIOR, TEMP_MIN);
      send_word(OP_LOAD, 0, 1, KIND_UNUSED_HI, 24'sd4096);
      send_word(OP_COMPUTE, 0, 0, KIND_FIRST_ROW, '0);
      send_word(OP_COMPUTE, 0, 0, KIND_LAST_ROW, '0);
      // non-edge kinds on an edge cell are rejected
      send_word(OP_COMPUTE, 0, 0, KIND_INTERIOR, '0);
      send_word(OP_COMPUTE, 0, 0, KIND_UNUSED_HI, '0);
      send_word(OP_LOAD, 63, 63, KIND_INTERIOR, TEMP_MIN);
      send_word(OP_LOAD, 62, 63, KIND_INTERIOR, TEMP_MAX);
      send_word(OP_LOAD, 63, 62, KIND_INTERIOR, TEMP_MAX);
      send_word(OP_COMPUTE, 63, 63, KIND_LAST_COL, '0);
      send_word(OP_COMPUTE, 63, 63, KIND_FIRST_COL, '0);
      send_word(OP_COMPUTE, 63, 63, KIND_UNUSED_LO, '0);
      send_word(OP_LOAD, 1, 1, KIND_INTERIOR, -24'sd12288);
      send_word(OP_LOAD, 2, 1, KIND_INTERIOR, 24'sd40960);
      send_word(OP_LOAD, 1, 2, KIND_INTERIOR, -24'sd1);
      send_word(OP_COMPUTE, 1, 1, KIND_INTERIOR, '0);
      send_word(OP_COMPUTE, 1, 1, KIND_UNUSED_HI, '0);
      send_word(OP_COMPUTE, 1, 1, KIND_LAST_ROW, '0);
      send_word(OP_KEEP, 0, 0, KIND_INTERIOR, '0);
      send_word(OP_KEEP, 63, 63, KIND_UNUSED_HI, TEMP_MAX);
      send_word(OP_ADVANCE, 63, 63, KIND_UNUSED_HI, -24'sd1);
   endtask

   task automatic test_register_extremes();
      // ratio above the cap, rows below the floor, cols above the ceiling
      configure('1, '0, '1);
      run_sweeps(2, 20);
      // upper bits of the size words are dropped: 3x3 grid
      configure(RATIO_MAX, 15'h7F83, RATIO_W'(3));
      run_sweeps(2, 25);
      configure('0, RATIO_W'(MAX_ROWS), RATIO_W'(MAX_COLS));
      run_sweeps(1, 10);
   endtask

   task automatic test_random_traffic(int sender_idle, int receiver_idle, int word_budget);
      int stop_at;
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at) begin
         configure(pick_ratio(), pick_dim(), pick_dim());
         run_sweeps($urandom_range(1, 3), 10);
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(RATIO_MAX, RATIO_W'(8), RATIO_W'(8));
      // hold the receiver off while the sender keeps offering words
      @(posedge clock);
      stall_request = STALL_CYCLES;
      @(negedge clock);
      run_sweeps(1, 0);
      drain_results();
      run_sweeps(1, 5);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 57;
      test_directed_cells();
      test_register_extremes();
      test_random_traffic(19, 57, 400);
      test_random_traffic(57, 19, 400);
      test_random_traffic(0, 0, 400);
      test_backpressure();
      drain_results();
      $display("summary: %0d words: %0d loads, %0d computes, %0d keeps, %0d advances",
               words_sent, op_tally[OP_LOAD], op_tally[OP_COMPUTE], op_tally[OP_KEEP],
               op_tally[OP_ADVANCE]);
      $display("summary: %0d rejected words over %0d register settings", rejects,
               settings_used);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
